### rtl/rsms_pkg.sv
// Shared types and constants for the row statistics unit.
package rsms_pkg;

  localparam int VALUE_W    = 16;  // width of one row element
  localparam int ROW_SUM_W  = 21;  // width of the reported row sum
  localparam int FIX_W      = 24;  // width of the reported mean and deviation
  localparam int MEAN_SHIFT = 8;   // fractional bits of the mean
  localparam int DEV_SHIFT  = 16;  // fractional bits of the variance before the root

  typedef enum logic [2:0] {
    ST_ACC,    // accumulating elements
    ST_DRAIN,  // final element still in the squaring stage
    ST_LOAD,   // accumulators final, start the serial multiplier
    ST_MUL,    // forming n*sumsq - sum^2 and n^2
    ST_DIVD,   // dividing the scaled numerator by n^2
    ST_FIN     // root and mean division in flight, then hand over the result
  } rsms_state_t;

endpackage

### rtl/rsms_if.sv
// Valid/ready channel interfaces for the element input and the row result.
interface rsms_in_if;
  import rsms_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last_element;

  modport source (output valid, output value, output last_element, input ready);
  modport sink   (input valid, input value, input last_element, output ready);
endinterface

interface rsms_out_if;
  import rsms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ROW_SUM_W-1:0] row_sum;
  logic [FIX_W-1:0]     row_mean;
  logic [FIX_W-1:0]     row_deviation;
  logic                 too_many;

  modport source (output valid, output row_sum, output row_mean, output row_deviation,
                  output too_many, input ready);
  modport sink   (input valid, input row_sum, input row_mean, input row_deviation,
                  input too_many, output ready);
endinterface

### rtl/rsms_accum.sv
// Two-stage accumulator: squares each element, then adds it into the row totals.
module rsms_accum #(
  parameter int MAX_COUNT = 32,
  parameter int CNT_W     = $clog2(MAX_COUNT + 1),
  parameter int SUM_W     = rsms_pkg::VALUE_W + CNT_W,
  parameter int SQS_W     = 2 * rsms_pkg::VALUE_W + CNT_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [rsms_pkg::VALUE_W-1:0] value,
  input  logic                         clear,
  output logic [CNT_W-1:0]             count,
  output logic [SUM_W-1:0]             sum,
  output logic [SQS_W-1:0]             sum_sq,
  output logic                         ovf
);
  import rsms_pkg::*;

  localparam int SQ_W = 2 * VALUE_W;

  logic               s1_vld_r;
  logic [VALUE_W-1:0] s1_val_r;
  logic [SQ_W-1:0]    s1_sq_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SQS_W-1:0]   sum_sq_r;
  logic               ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= take;
    end
  end

  // The square is registered before it meets the wide adder.
  always_ff @(posedge clk) begin
    s1_val_r <= value;
    s1_sq_r  <= SQ_W'(value) * SQ_W'(value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r  <= '0;
      sum_r    <= '0;
      sum_sq_r <= '0;
      ovf_r    <= 1'b0;
    end else if (s1_vld_r) begin
      if (count_r < CNT_W'(MAX_COUNT)) begin
        count_r  <= count_r + CNT_W'(1);
        sum_r    <= sum_r + SUM_W'(s1_val_r);
        sum_sq_r <= sum_sq_r + SQS_W'(s1_sq_r);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign count  = count_r;
  assign sum    = sum_r;
  assign sum_sq = sum_sq_r;
  assign ovf    = ovf_r;

endmodule

### rtl/rsms_var.sv
// Bit-serial shift-and-add unit forming n*sumsq - sum^2 and n^2.
module rsms_var #(
  parameter int CNT_W = 6,
  parameter int SUM_W = 22,
  parameter int SQS_W = 38,
  parameter int D_W   = SQS_W + CNT_W,
  parameter int NN_W  = 2 * CNT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] n,
  input  logic [SUM_W-1:0] sum,
  input  logic [SQS_W-1:0] sum_sq,
  output logic             busy,
  output logic [D_W-1:0]   numer,
  output logic [NN_W-1:0]  nn
);
  import rsms_pkg::*;

  localparam int IC_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic [IC_W-1:0]  cnt_r;
  logic             ph_r;      // low: multiplier bits of n, high: bits of sum
  logic [SUM_W-1:0] mbits_r;
  logic [D_W-1:0]   addend_r;
  logic [NN_W-1:0]  nsh_r;
  logic [D_W-1:0]   numer_r;
  logic [NN_W-1:0]  nn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      ph_r   <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= IC_W'(CNT_W);
      ph_r   <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r == IC_W'(1)) begin
        if (ph_r) begin
          busy_r <= 1'b0;
        end else begin
          ph_r  <= 1'b1;
          cnt_r <= IC_W'(SUM_W);
        end
      end else begin
        cnt_r <= cnt_r - IC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mbits_r  <= SUM_W'(n);
      addend_r <= D_W'(sum_sq);
      nsh_r    <= NN_W'(n);
      numer_r  <= '0;
      nn_r     <= '0;
    end else if (busy_r) begin
      if (!ph_r) begin
        if (mbits_r[0]) begin
          numer_r <= numer_r + addend_r;
          nn_r    <= nn_r + nsh_r;
        end
        nsh_r <= nsh_r << 1;
      end else if (mbits_r[0]) begin
        numer_r <= numer_r - addend_r;
      end
      // At the end of the first pass the sum becomes the multiplier and multiplicand.
      if (!ph_r && cnt_r == IC_W'(1)) begin
        mbits_r  <= sum;
        addend_r <= D_W'(sum);
      end else begin
        mbits_r  <= mbits_r >> 1;
        addend_r <= addend_r << 1;
      end
    end
  end

  assign busy  = busy_r;
  assign numer = numer_r;
  assign nn    = nn_r;

endmodule

### rtl/rsms_div.sv
// Restoring divider producing one quotient bit per cycle.
module rsms_div #(
  parameter int X_W = 60,
  parameter int Y_W = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] dividend,
  input  logic [Y_W-1:0] divisor,
  output logic           busy,
  output logic [X_W-1:0] quotient
);
  import rsms_pkg::*;

  localparam int IC_W = $clog2(X_W + 1);

  logic            busy_r;
  logic [IC_W-1:0] cnt_r;
  logic [X_W-1:0]  x_r;    // dividend bits leave at the top, quotient bits enter below
  logic [Y_W-1:0]  rem_r;
  logic [Y_W-1:0]  dvs_r;
  logic [Y_W:0]    trial;
  logic [Y_W:0]    diff;
  logic            ge;

  assign trial = {rem_r, x_r[X_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= IC_W'(X_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - IC_W'(1);
      if (cnt_r == IC_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      x_r   <= {x_r[X_W-2:0], ge};
      rem_r <= ge ? diff[Y_W-1:0] : trial[Y_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = x_r;

endmodule

### rtl/rsms_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module rsms_sqrt #(
  parameter int X_W = 60,
  parameter int R_W = X_W / 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] radicand,
  output logic           busy,
  output logic [R_W-1:0] root
);
  import rsms_pkg::*;

  localparam int IC_W = $clog2(R_W + 1);

  logic            busy_r;
  logic [IC_W-1:0] cnt_r;
  logic [X_W-1:0]  x_r;
  logic [R_W:0]    rem_r;
  logic [R_W-1:0]  root_r;
  logic [R_W+2:0]  trial;
  logic [R_W+2:0]  test;
  logic [R_W+2:0]  diff;
  logic            ge;

  // Bring down the next pair of radicand bits and try 4*root + 1.
  assign trial = {rem_r, x_r[X_W-1:X_W-2]};
  assign test  = {1'b0, root_r, 2'b01};
  assign ge    = trial >= test;
  assign diff  = trial - test;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= IC_W'(R_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - IC_W'(1);
      if (cnt_r == IC_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[X_W-3:0], 2'b00};
      rem_r  <= ge ? diff[R_W:0] : trial[R_W:0];
      root_r <= {root_r[R_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

### rtl/row_sum_mean_stddev_unit.sv
// Row sum, mean and deviation unit: while the unit accumulates, one element is transferred
// per cycle, squared, then added. After the last element of a row the input stalls while the
// serial multiplier runs and the divider runs twice; the square root overlaps the second
// division. The result is presented at the edge that ends the stall, and the stall lasts
// longer only while the previous result still waits to be taken.
// Synchronous active-low reset empties the pipeline, clears all totals and drops any result.
module row_sum_mean_stddev_unit #(
  parameter int MAX_COUNT = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  rsms_in_if.sink          in_ch,
  rsms_out_if.source       out_ch
);
  import rsms_pkg::*;

  // Accumulators are held exactly, so every width follows from the row capacity.
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int SUM_W     = VALUE_W + CNT_W;
  localparam int SQS_W     = 2 * VALUE_W + CNT_W;
  localparam int D_W       = SQS_W + CNT_W;
  localparam int NN_W      = 2 * CNT_W;
  localparam int X_W       = D_W + DEV_SHIFT;
  localparam int R_W       = X_W / 2;
  localparam int SUM_X_W   = SUM_W + ROW_SUM_W;

  rsms_state_t state_r;
  rsms_state_t state_nxt;

  logic             in_take;
  logic             acc_clear;
  logic [CNT_W-1:0] acc_n;
  logic [SUM_W-1:0] acc_sum;
  logic [SQS_W-1:0] acc_sum_sq;
  logic             acc_ovf;

  logic             var_start;
  logic             var_busy;
  logic [D_W-1:0]   var_numer;
  logic [NN_W-1:0]  var_nn;

  logic             div_start;
  logic             div_busy;
  logic [X_W-1:0]   div_dividend;
  logic [NN_W-1:0]  div_divisor;
  logic [X_W-1:0]   div_quo;

  logic             sqrt_start;
  logic             sqrt_busy;
  logic [R_W-1:0]   sqrt_root;

  logic                 out_load;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [ROW_SUM_W-1:0] out_sum_r;
  logic [FIX_W-1:0]     out_mean_r;
  logic [FIX_W-1:0]     out_dev_r;
  logic                 out_too_many_r;
  logic [SUM_X_W-1:0]   sum_ext;

  // Elements are only taken while accumulating; the last one closes the row.
  assign in_ch.ready = (state_r == ST_ACC);
  assign in_take     = in_ch.valid && in_ch.ready;

  rsms_accum #(
    .MAX_COUNT (MAX_COUNT),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .SQS_W     (SQS_W)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (in_take),
    .value  (in_ch.value),
    .clear  (acc_clear),
    .count  (acc_n),
    .sum    (acc_sum),
    .sum_sq (acc_sum_sq),
    .ovf    (acc_ovf)
  );

  rsms_var #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .SQS_W (SQS_W),
    .D_W   (D_W),
    .NN_W  (NN_W)
  ) u_var (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (var_start),
    .n      (acc_n),
    .sum    (acc_sum),
    .sum_sq (acc_sum_sq),
    .busy   (var_busy),
    .numer  (var_numer),
    .nn     (var_nn)
  );

  // The one divider serves both quotients: first the scaled variance over n^2,
  // then the scaled sum over n while the root is being extracted.
  always_comb begin
    if (state_r == ST_MUL) begin
      div_dividend = {var_numer, {DEV_SHIFT{1'b0}}};
      div_divisor  = var_nn;
    end else begin
      div_dividend = X_W'({acc_sum, {MEAN_SHIFT{1'b0}}});
      div_divisor  = NN_W'(acc_n);
    end
  end

  rsms_div #(
    .X_W (X_W),
    .Y_W (NN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  rsms_sqrt #(
    .X_W (X_W),
    .R_W (R_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_quo),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer for the end-of-row arithmetic. Each unit is started on the edge
  // that enters the state which then waits for it to fall idle.
  always_comb begin
    state_nxt  = state_r;
    var_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    acc_clear  = 1'b0;
    case (state_r)
      ST_ACC: begin
        if (in_take && in_ch.last_element) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        var_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (!var_busy) begin
          div_start = 1'b1;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (!div_busy) begin
          sqrt_start = 1'b1;
          div_start  = 1'b1;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        // The result may be handed over once the previous one has been taken.
        if (!div_busy && !sqrt_busy && (!out_valid_r || out_ch.ready)) begin
          out_load  = 1'b1;
          acc_clear = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  // Output register: the next row can be accumulated while this result waits.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sum_ext = SUM_X_W'(acc_sum);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r      <= sum_ext[ROW_SUM_W-1:0];
      out_mean_r     <= div_quo[FIX_W-1:0];
      out_dev_r      <= sqrt_root[FIX_W-1:0];
      out_too_many_r <= acc_ovf;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_sum       = out_sum_r;
  assign out_ch.row_mean      = out_mean_r;
  assign out_ch.row_deviation = out_dev_r;
  assign out_ch.too_many      = out_too_many_r;

  // Once a row is closed no further element may be taken until its result is out.
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_ch.last_element) |=> !in_ch.ready)
    else $error("element taken directly after the last element of a row");

  // The shared divider must never be restarted in the middle of a division.
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy)
    else $error("square root unit started while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_n <= CNT_W'(MAX_COUNT))
    else $error("element count beyond row capacity");

  // A fresh result can only appear at the end of the final arithmetic phase.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result presented outside the final phase");

endmodule
